@@ hdl/sdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_pkg: shared definitions for the sequence duplicate remover
// Store geometry, the memory request bundle and the result bundle that the
// sequencer hands to the output stage.
// ----------------------------------------------------------------------------
package sdr_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
        logic              end_of_run;
        logic              overflowed;
    } emit_t;

endpackage

@@ hdl/sdr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_store: value store
// One write port and one read port; read data is registered, so a read
// address issued in one cycle returns its data in the next.
// ----------------------------------------------------------------------------
module sdr_store (
    input  logic              clk,
    input  sdr_pkg::mem_req_t req,
    output logic [31:0]       rdata
);
    import sdr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/sdr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_ctrl: load and walk sequencer
// Appends values to the store, then walks it from the newest entry down,
// scanning the newer entries for each candidate and releasing the distinct
// ones. One distinct value is held back so the final one can carry the
// end-of-run mark.
// ----------------------------------------------------------------------------
module sdr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       value,
    input  logic              last,
    input  logic              out_free,
    input  logic [31:0]       rdata,
    output sdr_pkg::mem_req_t mem_req,
    output sdr_pkg::emit_t    emit
);
    import sdr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CAND,
        S_LATCH,
        S_SCAN,
        S_CMP,
        S_EMIT,
        S_NEXT,
        S_FLUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [DATA_W-1:0] cand_reg, cand_next;
    logic [DATA_W-1:0] pend_reg, pend_next;
    logic              have_pend_reg, have_pend_next;

    logic accept;
    logic full;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign full     = (fill_reg >= CNT_W'(DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        cand_next      = cand_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = fill_reg[ADDR_W-1:0];
        mem_req.wdata = value;
        mem_req.raddr = (state_reg == S_RD_CAND) ? pos_reg : j_reg[ADDR_W-1:0];

        emit.valid      = 1'b0;
        emit.value      = pend_reg;
        emit.end_of_run = 1'b0;
        emit.overflowed = ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                        fill_next  = fill_reg + CNT_W'(1);
                    end
                    if (last)
                    begin
                        // Newest stored entry; the store is never empty here.
                        pos_next   = full ? ADDR_W'(DEPTH - 1) : fill_reg[ADDR_W-1:0];
                        state_next = S_RD_CAND;
                    end
                end
            end
            S_RD_CAND:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                cand_next  = rdata;
                j_next     = CNT_W'(pos_reg) + CNT_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (j_reg >= fill_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rdata == cand_reg)
                begin
                    // A newer copy exists, so this one is skipped.
                    state_next = S_NEXT;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                if (!have_pend_reg)
                begin
                    pend_next      = cand_reg;
                    have_pend_next = 1'b1;
                    state_next     = S_NEXT;
                end
                else if (out_free)
                begin
                    emit.valid = 1'b1;
                    pend_next  = cand_reg;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = S_RD_CAND;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit.valid      = 1'b1;
                    emit.end_of_run = 1'b1;
                    have_pend_next  = 1'b0;
                    fill_next       = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            have_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            have_pend_reg <= have_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        j_reg    <= j_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
    end

endmodule

@@ hdl/sequence_duplicate_remover_unit.sv @@
`timescale 1ns / 1ps
// Loading: one beat per cycle, written unless the store is full; input stalls during a walk.
// Walk: each entry is read and latched, then each newer entry is read and compared through
// the single read port (registered read data); a distinct entry then goes to S_EMIT.
// The first result is registered once a second distinct value is found, else by S_FLUSH.
// Reset (rst_n, asynchronous, active low) empties the store and clears overflow; no
// clearing pass is needed since entries are never read before they are written.
// ----------------------------------------------------------------------------
// sequence_duplicate_remover_unit: top level
// Loads signed values into the store and, on the final beat, returns the
// distinct values newest first through a registered output stage.
// ----------------------------------------------------------------------------
module sequence_duplicate_remover_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] distinct_value,
    output logic        end_of_run,
    output logic        overflowed
);
    import sdr_pkg::*;

    mem_req_t          mem_req;
    emit_t             emit;
    logic [DATA_W-1:0] rdata;
    logic              out_free;

    logic              out_valid_reg;
    logic [DATA_W-1:0] value_reg;
    logic              eor_reg;
    logic              ovf_reg;

    assign out_free = !out_valid_reg || !out_stall;

    sdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .last     (last),
        .out_free (out_free),
        .rdata    (rdata),
        .mem_req  (mem_req),
        .emit     (emit)
    );

    sdr_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit.valid)
        begin
            value_reg <= emit.value;
            eor_reg   <= emit.end_of_run;
            ovf_reg   <= emit.overflowed;
        end
    end

    assign out_valid      = out_valid_reg;
    assign distinct_value = value_reg;
    assign end_of_run     = eor_reg;
    assign overflowed     = ovf_reg;

endmodule

@@ hdl/sdr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_checker: port-level checks for the duplicate remover
// Watches the handshakes and the run framing seen at the top level.
// ----------------------------------------------------------------------------
module sdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] distinct_value,
    input logic        end_of_run,
    input logic        overflowed
);

    // A final input beat starts a walk, so the input must stall right after it.
    a_walk_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input not stalled after final beat");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distinct_value)
            && $stable(end_of_run) && $stable(overflowed))
        else $error("stalled result beat changed");

    // A result beat never carries unknown bits.
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({distinct_value, end_of_run, overflowed}))
        else $error("unknown bits on a result beat");

    // While a run is still being delivered, no new input is taken.
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_run |-> in_stall)
        else $error("input accepted in the middle of a run");

endmodule

bind sequence_duplicate_remover_unit sdr_checker u_sdr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .distinct_value (distinct_value),
    .end_of_run     (end_of_run),
    .overflowed     (overflowed)
);
